[src/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// Base64 encoder package
// Types, constants and the alphabet lookup shared by the encoder modules.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int CHAR_W      = 7;
    localparam int JOB_CHARS   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'h3D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 7'h2B;
    localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'h2F;
    localparam logic [CHAR_W-1:0] UPPER_A    = 7'h41;
    localparam logic [CHAR_W-1:0] LOWER_A    = 7'h61;
    localparam logic [CHAR_W-1:0] DIGIT_0    = 7'h30;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // Characters produced by one input byte
    typedef struct packed {
        logic [JOB_CHARS-1:0][CHAR_W-1:0] chars;
        logic [1:0]                       last_idx;   // index of final char in job
        logic                             msg_end;    // final char closes the message
    } job_t;

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] idx);
        logic [CHAR_W-1:0] res;
        logic [CHAR_W-1:0] wide;
        wide = {1'b0, idx};
        if (idx < 6'd26)
            res = UPPER_A + wide;
        else if (idx < 6'd52)
            res = LOWER_A + wide - 7'd26;
        else if (idx < 6'd62)
            res = DIGIT_0 + wide - 7'd52;
        else if (idx == 6'd62)
            res = PLUS_CHAR;
        else
            res = SLASH_CHAR;
        return res;
    endfunction

endpackage

[src/b64e_front.sv]
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts message bytes, tracks the group phase and left-over bits, and
// turns each byte into a job of one to four characters.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // [7:0] data_byte
    input  logic          s_tlast,    // end_of_message
    input  logic          q_full,
    output logic          q_push,
    output b64e_pkg::job_t q_job
);
    import b64e_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic [7:0] b;

    assign b        = s_tdata;
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb
    begin
        q_job         = '0;
        q_job.msg_end = s_tlast;
        phase_next    = PHASE_FIRST;
        carry_next    = 4'd0;
        case (phase_reg)
            PHASE_SECOND:
            begin
                q_job.chars[0] = sextet_char({carry_reg[1:0], b[7:4]});
                if (s_tlast)
                begin
                    q_job.chars[1] = sextet_char({b[3:0], 2'b00});
                    q_job.chars[2] = PAD_CHAR;
                    q_job.last_idx = 2'd2;
                end
                else
                begin
                    q_job.last_idx = 2'd0;
                    phase_next     = PHASE_THIRD;
                    carry_next     = b[3:0];
                end
            end
            PHASE_THIRD:
            begin
                q_job.chars[0] = sextet_char({carry_reg, b[7:6]});
                q_job.chars[1] = sextet_char(b[5:0]);
                q_job.last_idx = 2'd1;
            end
            default:
            begin
                // unused phase code behaves as the start of a group
                q_job.chars[0] = sextet_char(b[7:2]);
                if (s_tlast)
                begin
                    q_job.chars[1] = sextet_char({b[1:0], 4'b0000});
                    q_job.chars[2] = PAD_CHAR;
                    q_job.chars[3] = PAD_CHAR;
                    q_job.last_idx = 2'd3;
                end
                else
                begin
                    q_job.last_idx = 2'd0;
                    phase_next     = PHASE_SECOND;
                    carry_next     = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_FIRST;
            carry_reg <= 4'd0;
        end
        else if (q_push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

[src/b64e_queue.sv]
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Short FIFO of character jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module b64e_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64e_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output b64e_pkg::job_t head_job
);
    import b64e_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

endmodule

[src/b64e_back.sv]
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Walks the head job one character per beat into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  b64e_pkg::job_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // [6:0] out_char, [7] zero fill
    output logic           m_tlast    // last_char
);
    import b64e_pkg::*;

    logic [1:0]        idx_reg;
    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              load;
    logic              job_done;

    assign load     = !q_empty && (!valid_reg || m_tready);
    assign job_done = (idx_reg == q_head.last_idx);
    assign q_pop    = load && job_done;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= job_done ? 2'd0 : idx_reg + 2'd1;
            end
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= q_head.chars[idx_reg];
            last_reg <= q_head.msg_end && job_done;
        end
    end

    // a job partly sent stays at the head of the queue
    a_partial_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> !q_empty)
        else $error("character index set with no job in queue");

endmodule

[src/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into standard-alphabet Base64 characters with '='
// padding at the end of each message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one message byte per beat in s_tdata, s_tlast set on
//   the final byte of the message. Output channel m_*: one ASCII character
//   per beat in m_tdata[6:0], m_tlast set on the final character (after any
//   '=' padding) of the encoded message.
//   Each byte makes one or two characters; the final byte of a message makes
//   two to four. The first character of a byte enters the output register
//   once the byte's job is in the queue and the output register is free;
//   characters then leave one per cycle while m_tready is high.
//   Throughput is bounded by the output register, one character per cycle
//   while m_tready is high, and the front end takes a byte every cycle
//   while the two-entry job queue has room.
//   A stalled receiver holds the output register; the queue then fills and
//   s_tready drops until the back end drains a job.
//   Reset clears the group phase, the left-over bits, the queue and the
//   output valid flag; the first byte after reset starts a new group.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [6:0] out_char, [7] zero fill
    output logic       m_tlast     // last_char
);
    import b64e_pkg::*;

    job_t push_job;
    job_t head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_job    (push_job)
    );

    b64e_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_job (head_job)
    );

    b64e_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (empty),
        .q_head   (head_job),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
